@@ src/mersenne_twister_64_generator_assert.svh @@
// Assertion macros shared by the generator's checking code.
`ifndef MERSENNE_TWISTER_64_GENERATOR_ASSERT_SVH
`define MERSENNE_TWISTER_64_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The expression must hold at every clock edge outside reset.
`define MTG_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

@@ src/mtg_pkg.sv @@
// Package with constants, command types and the tempering function of the generator.
package mtg_pkg;

   localparam int STATE_WORDS  = 312;
   localparam int TWIST_OFFSET = 156;
   localparam int INDEX_W      = $clog2(STATE_WORDS + 2);

   localparam logic [INDEX_W-1:0] INDEX_FULL     = INDEX_W'(STATE_WORDS);
   localparam logic [INDEX_W-1:0] INDEX_UNSEEDED = INDEX_W'(STATE_WORDS + 1);
   localparam logic [INDEX_W-1:0] LAST_WORD      = INDEX_W'(STATE_WORDS - 1);
   localparam logic [INDEX_W-1:0] HALF_OFFSET    = INDEX_W'(TWIST_OFFSET);

   localparam logic [63:0] SEED_MULT    = 64'd6364136223846793005;
   localparam logic [63:0] TWIST_MATRIX = 64'hB5026F5AA96619E9;
   localparam logic [63:0] SEED_DEFAULT = 64'd5489;
   localparam logic [63:0] TEMPER_B     = 64'h5555555555555555;
   localparam logic [63:0] TEMPER_C     = 64'h71D67FFFEDA60000;
   localparam logic [63:0] TEMPER_D     = 64'hFFF7EEE000000000;

   // Multiplier operand selection for the seeding product.
   localparam logic [1:0] MUL_LL = 2'd0;
   localparam logic [1:0] MUL_HL = 2'd1;
   localparam logic [1:0] MUL_LH = 2'd2;
   localparam logic [1:0] MUL_NA = 2'd3;

   // Accumulator operations.
   localparam logic [1:0] ACC_HOLD  = 2'd0;
   localparam logic [1:0] ACC_INIT  = 2'd1;
   localparam logic [1:0] ACC_FULL  = 2'd2;
   localparam logic [1:0] ACC_SHIFT = 2'd3;

   // State memory read address selection.
   localparam logic [1:0] RD_CUR  = 2'd0;
   localparam logic [1:0] RD_NEXT = 2'd1;
   localparam logic [1:0] RD_FAR  = 2'd2;
   localparam logic [1:0] RD_NA   = 2'd3;

   typedef struct packed {
      logic       seed_start;
      logic [1:0] mul_sel;
      logic [1:0] acc_op;
      logic       seed_write;
      logic       seed_done;
      logic       draw_start;
      logic [1:0] rd_sel;
      logic       hi_capture;
      logic       lo_capture;
      logic       twist_write;
      logic       out_load;
   } mtg_cmd_type;

   typedef struct packed {
      logic unseeded;
      logic seed_last;
   } mtg_status_type;

   function automatic logic [63:0] temper(input logic [63:0] x);
      logic [63:0] t;
      t = x ^ ((x >> 29) & TEMPER_B);
      t = t ^ ((t << 17) & TEMPER_C);
      t = t ^ ((t << 37) & TEMPER_D);
      t = t ^ (t >> 43);
      return t;
   endfunction

endpackage

@@ src/mtg_datapath.sv @@
// Datapath: state memory, seeding multiplier, lazy twist and tempering output register.
module mtg_datapath
   import mtg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           seed_write_en,
   input  logic [63:0]    seed_write_value,
   input  mtg_cmd_type    cmd,
   output mtg_status_type status,
   output logic [63:0]    random_word
);

   logic [63:0]        mem [STATE_WORDS];
   logic [63:0]        seed_ff;
   logic [INDEX_W-1:0] ri_ff, ri_in;
   logic [INDEX_W-1:0] widx_ff, widx_in;
   logic [INDEX_W-1:0] draw_ff, draw_in;
   logic [63:0]        w_ff, w_in;
   logic [63:0]        acc_ff, acc_in;
   logic [63:0]        prod_ff, prod_in;
   logic [63:0]        rd_data_ff;
   logic [63:0]        y_ff, y_in;
   logic [63:0]        tw_ff, tw_in;
   logic [63:0]        out_ff, out_in;

   logic [63:0]        mix;
   logic [31:0]        mul_a, mul_b;
   logic [INDEX_W-1:0] rd_addr, next_addr, far_addr;
   logic               wr_en;
   logic [INDEX_W-1:0] wr_addr;
   logic [63:0]        wr_data;

   assign mix = w_ff ^ (w_ff >> 62);

   always_comb begin
      case (cmd.mul_sel)
         MUL_LL: begin
            mul_a = mix[31:0];
            mul_b = SEED_MULT[31:0];
         end
         MUL_HL: begin
            mul_a = mix[63:32];
            mul_b = SEED_MULT[31:0];
         end
         MUL_LH: begin
            mul_a = mix[31:0];
            mul_b = SEED_MULT[63:32];
         end
         default: begin
            mul_a = mix[31:0];
            mul_b = SEED_MULT[31:0];
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // The low 64 bits of the seeding product come from three partial products.
   always_comb begin
      case (cmd.acc_op)
         ACC_INIT:  acc_in = {{(64-INDEX_W){1'b0}}, widx_ff};
         ACC_FULL:  acc_in = acc_ff + prod_ff;
         ACC_SHIFT: acc_in = acc_ff + {prod_ff[31:0], 32'b0};
         default:   acc_in = acc_ff;
      endcase
   end

   assign next_addr = (draw_ff == LAST_WORD) ? '0 : draw_ff + 1'b1;
   assign far_addr  = (draw_ff < HALF_OFFSET) ? draw_ff + HALF_OFFSET : draw_ff - HALF_OFFSET;

   always_comb begin
      case (cmd.rd_sel)
         RD_CUR:  rd_addr = draw_ff;
         RD_NEXT: rd_addr = next_addr;
         RD_FAR:  rd_addr = far_addr;
         default: rd_addr = draw_ff;
      endcase
   end

   // Words below the draw index already hold their twisted values, so reading
   // the neighbors straight from memory matches a full twist pass.
   assign tw_in = rd_data_ff ^ (y_ff >> 1) ^ (y_ff[0] ? TWIST_MATRIX : 64'd0);

   always_comb begin
      y_in = y_ff;
      if (cmd.hi_capture) y_in[63:31] = rd_data_ff[63:31];
      if (cmd.lo_capture) y_in[30:0] = rd_data_ff[30:0];
   end

   always_comb begin
      wr_en   = cmd.seed_start || cmd.seed_write || cmd.twist_write;
      wr_addr = draw_ff;
      wr_data = tw_in;
      if (cmd.seed_start) begin
         wr_addr = '0;
         wr_data = seed_ff;
      end else if (cmd.seed_write) begin
         wr_addr = widx_ff;
         wr_data = acc_ff;
      end
   end

   always_comb begin
      ri_in   = ri_ff;
      widx_in = widx_ff;
      draw_in = draw_ff;
      w_in    = w_ff;
      out_in  = out_ff;
      if (cmd.seed_start) begin
         widx_in = INDEX_W'(1);
         w_in    = seed_ff;
      end
      if (cmd.seed_write) begin
         widx_in = widx_ff + 1'b1;
         w_in    = acc_ff;
      end
      if (cmd.seed_done) ri_in = INDEX_FULL;
      if (cmd.draw_start) draw_in = (ri_ff >= INDEX_FULL) ? '0 : ri_ff;
      if (cmd.twist_write) ri_in = draw_ff + 1'b1;
      if (cmd.out_load) out_in = temper(tw_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_DEFAULT;
         ri_ff   <= INDEX_UNSEEDED;
      end else begin
         if (seed_write_en) seed_ff <= seed_write_value;
         ri_ff <= ri_in;
      end
   end

   always_ff @(posedge clock) begin
      widx_ff <= widx_in;
      draw_ff <= draw_in;
      w_ff    <= w_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      y_ff    <= y_in;
      if (cmd.twist_write) tw_ff <= tw_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign status.unseeded  = ri_ff > INDEX_FULL;
   assign status.seed_last = widx_ff == LAST_WORD;
   assign random_word      = out_ff;

endmodule

@@ src/mtg_controller.sv @@
// Controller: sequences seeding, the lazy twist of one word and the result handshake.
module mtg_controller
   import mtg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic           req_restart,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  mtg_status_type status,
   output mtg_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_M0    = 4'd1;
   localparam logic [3:0] ST_M1    = 4'd2;
   localparam logic [3:0] ST_M2    = 4'd3;
   localparam logic [3:0] ST_M3    = 4'd4;
   localparam logic [3:0] ST_M4    = 4'd5;
   localparam logic [3:0] ST_DRAW  = 4'd6;
   localparam logic [3:0] ST_R0    = 4'd7;
   localparam logic [3:0] ST_R1    = 4'd8;
   localparam logic [3:0] ST_R2    = 4'd9;
   localparam logic [3:0] ST_R3    = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept, out_free;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = MUL_NA;
      cmd.acc_op   = ACC_HOLD;
      cmd.rd_sel   = RD_NA;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_restart || status.unseeded) begin
                  cmd.seed_start = 1'b1;
                  state_in       = ST_M0;
               end else begin
                  cmd.draw_start = 1'b1;
                  state_in       = ST_R0;
               end
            end
         end
         ST_M0: begin
            cmd.mul_sel = MUL_LL;
            cmd.acc_op  = ACC_INIT;
            state_in    = ST_M1;
         end
         ST_M1: begin
            cmd.mul_sel = MUL_HL;
            cmd.acc_op  = ACC_FULL;
            state_in    = ST_M2;
         end
         ST_M2: begin
            cmd.mul_sel = MUL_LH;
            cmd.acc_op  = ACC_SHIFT;
            state_in    = ST_M3;
         end
         ST_M3: begin
            cmd.acc_op = ACC_SHIFT;
            state_in   = ST_M4;
         end
         ST_M4: begin
            cmd.seed_write = 1'b1;
            if (status.seed_last) begin
               cmd.seed_done = 1'b1;
               state_in      = ST_DRAW;
            end else begin
               state_in = ST_M0;
            end
         end
         ST_DRAW: begin
            cmd.draw_start = 1'b1;
            state_in       = ST_R0;
         end
         ST_R0: begin
            cmd.rd_sel = RD_CUR;
            state_in   = ST_R1;
         end
         ST_R1: begin
            cmd.hi_capture = 1'b1;
            cmd.rd_sel     = RD_NEXT;
            state_in       = ST_R2;
         end
         ST_R2: begin
            cmd.lo_capture = 1'b1;
            cmd.rd_sel     = RD_FAR;
            state_in       = ST_R3;
         end
         ST_R3: begin
            cmd.twist_write = 1'b1;
            state_in        = ST_OUT;
         end
         ST_OUT: begin
            // Hold the tempered word back until the output register is free.
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/mersenne_twister_64_generator.sv @@
// Top level of the 64-bit Mersenne Twister generator.
// Each request word returns one tempered 64-bit word. A plain draw runs from
// acceptance to the result register as three reads of the single
// read port of the 312-word state memory (the word, its neighbor and the word
// half a state away), a twist and write back, and the tempering.
// A request that seeds (the first after reset, or one with restart set) first
// runs the seed recurrence through a shared 32x32 multiplier, three partial
// products and a write-back for each of the 311 derived words, before its
// draw. The seed register may be written at any time the block is idle and
// takes effect at the next seeding.
`include "mersenne_twister_64_generator_assert.svh"

module mersenne_twister_64_generator
   import mtg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_random_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_seed_value
);

   mtg_cmd_type    cmd;
   mtg_status_type status;

   assign csr_ready = 1'b1;

   mtg_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   mtg_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .seed_write_en    (csr_valid && csr_ready),
      .seed_write_value (csr_seed_value),
      .cmd              (cmd),
      .status           (status),
      .random_word      (rsp_random_word)
   );

   `MTG_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "block took a word but did not stall")
   `MTG_ASSERT_SAME(a_no_result_overwrite, clock, reset, cmd.out_load, !rsp_valid || !rsp_stall, "pending result overwritten")
   `MTG_ASSERT_ALWAYS(a_single_write, clock, reset, $onehot0({cmd.seed_start, cmd.seed_write, cmd.twist_write}), "two writes to the state memory in one cycle")
   `MTG_ASSERT_SAME(a_seed_done_last, clock, reset, cmd.seed_done, status.seed_last, "seeding ended before the last word")

endmodule
